>>> hdl/udec_pkg.sv
// shared types, codes and helpers of the utf-8 line decoder
`default_nettype none

package udec_pkg;

  // kind of one result
  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_LINE_END = 2'd1,
    KIND_ERROR    = 2'd2
  } kind_e;

  // line end kinds
  typedef enum logic [3:0] {
    NL_CR     = 4'd0,
    NL_LF     = 4'd1,
    NL_CRLF   = 4'd2,
    NL_VT     = 4'd3,
    NL_FF     = 4'd4,
    NL_NEL    = 4'd5,
    NL_LS     = 4'd6,
    NL_PS     = 4'd7,
    NL_LENGTH = 4'd8,
    NL_EOS    = 4'd9
  } nl_e;

  // decode error codes
  typedef enum logic [1:0] {
    ERR_STRAY     = 2'd0,
    ERR_TRUNCATED = 2'd1,
    ERR_TOO_LONG  = 2'd2
  } err_e;

  localparam int unsigned CpW = 31;

  // line break codepoints
  localparam logic [CpW-1:0] CP_CR  = 31'h0D;
  localparam logic [CpW-1:0] CP_LF  = 31'h0A;
  localparam logic [CpW-1:0] CP_VT  = 31'h0B;
  localparam logic [CpW-1:0] CP_FF  = 31'h0C;
  localparam logic [CpW-1:0] CP_NEL = 31'h85;
  localparam logic [CpW-1:0] CP_LS  = 31'h2028;
  localparam logic [CpW-1:0] CP_PS  = 31'h2029;

  localparam logic [7:0] BYTE_LF        = 8'h0A;
  localparam logic [1:0] CONT_TAG       = 2'b10;
  localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

  // one result as it leaves the block
  typedef struct packed {
    kind_e          kind;
    logic [CpW-1:0] cp;
    nl_e            nl;
    err_e           ec;
    logic [3:0]     cnt;
  } result_t;

  // all results caused by one byte, packed from entry 0
  typedef struct packed {
    result_t [2:0] ent;
    logic [1:0]    n;
  } group_t;

  // count of leading ones of a byte
  function automatic logic [3:0] lead_ones(input logic [7:0] b);
    logic [3:0] r;
    priority casez (b)
      8'b0???????: r = 4'd0;
      8'b10??????: r = 4'd1;
      8'b110?????: r = 4'd2;
      8'b1110????: r = 4'd3;
      8'b11110???: r = 4'd4;
      8'b111110??: r = 4'd5;
      8'b1111110?: r = 4'd6;
      8'b11111110: r = 4'd7;
      default:     r = 4'd8;
    endcase
    return r;
  endfunction

  function automatic result_t make_char(input logic [CpW-1:0] cp);
    result_t r;
    r      = '0;
    r.kind = KIND_CHAR;
    r.cp   = cp;
    return r;
  endfunction

  function automatic result_t make_line_end(input nl_e nl);
    result_t r;
    r      = '0;
    r.kind = KIND_LINE_END;
    r.nl   = nl;
    return r;
  endfunction

  function automatic result_t make_error(input err_e ec, input logic [3:0] cnt);
    result_t r;
    r      = '0;
    r.kind = KIND_ERROR;
    r.ec   = ec;
    r.cnt  = cnt;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/utf8_line_decoder.sv
// top level of the utf-8 decoder with line-end classification
// usage:
//   input channel (in_valid_i / in_ready_o) takes one byte of the stream and
//   its end_of_stream flag per request. output channel (out_valid_o /
//   out_ready_i) gives decoded characters, line ends and decode errors, one
//   result per request, last_of_run_o marking the last result of a byte.
//   a byte gives zero to three results.
//   configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes
//   the line length limit; it is always ready, and the user must write it
//   only while the block is idle; the block itself does not enforce this.
// flow: a byte accepted into the input register is decoded and loaded into
//   the result buffer once that buffer is free; its first result is then on the output.
// throughput: one byte per cycle while out_ready_i is high and each byte
//   yields at most one result; a byte with more results holds the result
//   buffer until the single output port has handed out each of them.
// reset: decode state, line count and both buffers clear; the length limit
//   returns to 65535.
// stall: while out_ready_i is low the result stays put, the decoded group
//   waits in the result buffer and one more byte waits in the input
//   register, after which in_ready_o drops.
`default_nettype none

module utf8_line_decoder #(
  parameter int unsigned MAX_EXTRA_BYTES = 5
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_stream_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       result_kind_o,
  output logic [30:0]      codepoint_o,
  output logic [3:0]       newline_kind_o,
  output logic [1:0]       error_code_o,
  output logic [3:0]       error_byte_count_o,
  output logic             last_of_run_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  logic              in_v_q;
  logic [7:0]        byte_q;
  logic              eos_q;
  logic [15:0]       max_len_q;
  logic              free;
  logic              fire;
  udec_pkg::group_t  grp;
  udec_pkg::result_t res;

  assign fire        = in_v_q && free;
  assign in_ready_o  = !in_v_q || fire;
  assign cfg_ready_o = 1'b1;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
      eos_q  <= end_of_stream_i;
    end
  end

  // line length limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= udec_pkg::MAX_LEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  udec_step #(
    .MAX_EXTRA_BYTES(MAX_EXTRA_BYTES)
  ) u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .byte_i    (byte_q),
    .eos_i     (eos_q),
    .max_len_i (max_len_q),
    .grp_o     (grp)
  );

  udec_rbuf u_rbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .grp_i       (grp),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res),
    .last_o      (last_of_run_o)
  );

  // result fields
  assign result_kind_o      = res.kind;
  assign codepoint_o        = res.cp;
  assign newline_kind_o     = res.nl;
  assign error_code_o       = res.ec;
  assign error_byte_count_o = res.cnt;

endmodule

`default_nettype wire

>>> hdl/udec_step.sv
// decode state and the single-pass next-state and result logic for one byte
`default_nettype none

module udec_step #(
  parameter int unsigned MAX_EXTRA_BYTES = 5
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire logic [7:0]      byte_i,
  input  wire logic            eos_i,
  input  wire logic [15:0]     max_len_i,
  output udec_pkg::group_t     grp_o
);

  // widest partial codepoint: lead bits plus the decodable extra bytes
  localparam int unsigned PcW = 6 + 5 * MAX_EXTRA_BYTES;
  localparam logic [3:0] MaxX = 4'(MAX_EXTRA_BYTES);

  logic [PcW-1:0] pc_q, pc_d;
  logic [2:0]     br_q, br_d;
  logic [3:0]     bt_q, bt_d;
  logic           stl_q, stl_d;
  logic           crp_q, crp_d;
  logic [15:0]    ll_q, ll_d;

  udec_pkg::result_t  p_r, m1_r, m2_r;
  logic               p_v, m1_v, m2_v;
  logic               main_en, is_cont, use_start, fc_go;
  logic [3:0]         ones;
  logic [2:0]         extra;
  logic [PcW-1:0]     pc_acc;
  logic [3:0]         bt1;
  logic [2:0]         br1;
  logic [15:0]        ll_base, ll1;
  logic [udec_pkg::CpW-1:0] fc_cp;

  // next state and results of the byte in the input register
  always_comb begin
    pc_d    = pc_q;
    br_d    = br_q;
    bt_d    = bt_q;
    stl_d   = stl_q;
    crp_d   = crp_q;
    p_v     = 1'b0;
    m1_v    = 1'b0;
    m2_v    = 1'b0;
    p_r     = '0;
    m1_r    = '0;
    m2_r    = '0;
    main_en = 1'b1;
    fc_go   = 1'b0;
    fc_cp   = '0;
    ll_base = ll_q;
    ll1     = '0;
    is_cont   = (byte_i[7:6] == udec_pkg::CONT_TAG);
    use_start = (bt_q == 4'd0) || !is_cont;
    ones      = udec_pkg::lead_ones(byte_i);
    extra     = 3'(ones - 4'd1);
    bt1       = bt_q + 4'd1;
    br1       = br_q - 3'd1;
    if (bt_q <= MaxX) begin
      pc_acc = PcW'({pc_q, byte_i[5:0]});
    end else begin
      pc_acc = pc_q;
    end

    // a held cr is settled first
    if (crp_q) begin
      crp_d   = 1'b0;
      ll_base = '0;
      p_v     = 1'b1;
      if (byte_i == udec_pkg::BYTE_LF && bt_q == 4'd0) begin
        p_r     = udec_pkg::make_line_end(udec_pkg::NL_CRLF);
        main_en = 1'b0;
      end else begin
        p_r = udec_pkg::make_line_end(udec_pkg::NL_CR);
      end
    end

    if (main_en) begin
      // non-continuation byte inside a sequence closes it as truncated
      if (bt_q != 4'd0 && !is_cont) begin
        p_v = 1'b1;
        p_r = udec_pkg::make_error(
                (stl_q && bt_q > MaxX) ? udec_pkg::ERR_TOO_LONG : udec_pkg::ERR_TRUNCATED,
                bt_q);
        pc_d    = '0;
        br_d    = '0;
        bt_d    = '0;
        stl_d   = 1'b0;
        ll_base = '0;
      end

      if (use_start) begin
        // lead byte or single byte
        if (ones == 4'd0) begin
          fc_go = 1'b1;
          fc_cp = udec_pkg::CpW'(byte_i);
        end else if (ones == 4'd1) begin
          m1_v    = 1'b1;
          m1_r    = udec_pkg::make_error(udec_pkg::ERR_STRAY, 4'd1);
          ll_base = '0;
        end else if (eos_i) begin
          m1_v    = 1'b1;
          m1_r    = udec_pkg::make_error(udec_pkg::ERR_TRUNCATED, 4'd1);
          ll_base = '0;
        end else begin
          pc_d  = PcW'(byte_i & (8'hFF >> ones));
          br_d  = extra;
          bt_d  = 4'd1;
          stl_d = ({1'b0, extra} > MaxX);
        end
      end else begin
        // continuation byte
        if (br1 == 3'd0) begin
          pc_d  = '0;
          br_d  = '0;
          bt_d  = '0;
          stl_d = 1'b0;
          if (stl_q) begin
            m1_v    = 1'b1;
            m1_r    = udec_pkg::make_error(udec_pkg::ERR_TOO_LONG, bt1);
            ll_base = '0;
          end else begin
            fc_go = 1'b1;
            fc_cp = udec_pkg::CpW'(pc_acc);
          end
        end else if (eos_i) begin
          m1_v = 1'b1;
          m1_r = udec_pkg::make_error(
                   (stl_q && bt1 > MaxX) ? udec_pkg::ERR_TOO_LONG
                                         : udec_pkg::ERR_TRUNCATED,
                   bt1);
          pc_d    = '0;
          br_d    = '0;
          bt_d    = '0;
          stl_d   = 1'b0;
          ll_base = '0;
        end else begin
          pc_d = pc_acc;
          bt_d = bt1;
          br_d = br1;
        end
      end
    end

    ll_d = ll_base;
    // finished codepoint: line break, or character with length and end-of-stream check
    if (fc_go) begin
      unique case (fc_cp)
        udec_pkg::CP_CR: begin
          if (eos_i) begin
            m1_v = 1'b1;
            m1_r = udec_pkg::make_line_end(udec_pkg::NL_CR);
            ll_d = '0;
          end else begin
            crp_d = 1'b1;
          end
        end
        udec_pkg::CP_LF: begin
          m1_v = 1'b1;
          m1_r = udec_pkg::make_line_end(udec_pkg::NL_LF);
          ll_d = '0;
        end
        udec_pkg::CP_VT: begin
          m1_v = 1'b1;
          m1_r = udec_pkg::make_line_end(udec_pkg::NL_VT);
          ll_d = '0;
        end
        udec_pkg::CP_FF: begin
          m1_v = 1'b1;
          m1_r = udec_pkg::make_line_end(udec_pkg::NL_FF);
          ll_d = '0;
        end
        udec_pkg::CP_NEL: begin
          m1_v = 1'b1;
          m1_r = udec_pkg::make_line_end(udec_pkg::NL_NEL);
          ll_d = '0;
        end
        udec_pkg::CP_LS: begin
          m1_v = 1'b1;
          m1_r = udec_pkg::make_line_end(udec_pkg::NL_LS);
          ll_d = '0;
        end
        udec_pkg::CP_PS: begin
          m1_v = 1'b1;
          m1_r = udec_pkg::make_line_end(udec_pkg::NL_PS);
          ll_d = '0;
        end
        default: begin
          m1_v = 1'b1;
          m1_r = udec_pkg::make_char(fc_cp);
          ll1  = ll_base + 16'd1;
          if (ll1 >= max_len_i) begin
            m2_v = 1'b1;
            m2_r = udec_pkg::make_line_end(udec_pkg::NL_LENGTH);
            ll_d = '0;
          end else if (eos_i) begin
            m2_v = 1'b1;
            m2_r = udec_pkg::make_line_end(udec_pkg::NL_EOS);
            ll_d = '0;
          end else begin
            ll_d = ll1;
          end
        end
      endcase
    end
  end

  // pack the results from entry 0
  always_comb begin
    grp_o.n = 2'(p_v) + 2'(m1_v) + 2'(m2_v);
    if (p_v) begin
      grp_o.ent[0] = p_r;
      grp_o.ent[1] = m1_r;
      grp_o.ent[2] = m2_r;
    end else begin
      grp_o.ent[0] = m1_r;
      grp_o.ent[1] = m2_r;
      grp_o.ent[2] = '0;
    end
  end

  // decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= '0;
      br_q  <= '0;
      bt_q  <= '0;
      stl_q <= 1'b0;
      crp_q <= 1'b0;
      ll_q  <= '0;
    end else if (fire_i) begin
      pc_q  <= pc_d;
      br_q  <= br_d;
      bt_q  <= bt_d;
      stl_q <= stl_d;
      crp_q <= crp_d;
      ll_q  <= ll_d;
    end
  end

  // a held cr only follows a finished sequence
  a_crp_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crp_q |-> (bt_q == 4'd0))
    else $error("cr held inside an open sequence");

  // with no open sequence the sequence state is clear
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bt_q == 4'd0) |-> (br_q == 3'd0 && !stl_q && pc_q == '0))
    else $error("sequence state left over after close");

  // an open sequence always expects more bytes
  a_open_expects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bt_q != 4'd0) |-> (br_q != 3'd0))
    else $error("open sequence expects no bytes");

endmodule

`default_nettype wire

>>> hdl/udec_rbuf.sv
// result buffer: holds the results of one byte, handed out one a cycle while out_ready_i is high
`default_nettype none

module udec_rbuf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire udec_pkg::group_t  grp_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output udec_pkg::result_t      res_o,
  output logic                   last_o
);

  udec_pkg::result_t ent_q [0:2];
  logic [1:0]        cnt_q;
  logic [1:0]        rd_q;

  // buffer empties this cycle or is empty already
  assign free_o      = (rd_q == cnt_q) || ((rd_q + 2'd1 == cnt_q) && out_ready_i);
  assign out_valid_o = (rd_q != cnt_q);
  assign last_o      = (rd_q + 2'd1 == cnt_q);

  // entry under the read index
  always_comb begin
    unique case (rd_q)
      2'd0:    res_o = ent_q[0];
      2'd1:    res_o = ent_q[1];
      default: res_o = ent_q[2];
    endcase
  end

  // payload of the group
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q[0] <= grp_i.ent[0];
      ent_q[1] <= grp_i.ent[1];
      ent_q[2] <= grp_i.ent[2];
    end
  end

  // fill count and read index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (load_i) begin
      cnt_q <= grp_i.n;
      rd_q  <= '0;
    end else if (out_valid_o && out_ready_i) begin
      rd_q <= rd_q + 2'd1;
    end
  end

  a_rd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_q <= cnt_q)
    else $error("read index past fill count");

  // a new group never overwrites a result not yet taken
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!out_valid_o || (last_o && out_ready_i)))
    else $error("result group overwritten");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (res_o.kind != udec_pkg::KIND_ERROR ||
                                  rd_q == 2'd0))
    else $error("error result not first of its group");

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps
// testbench for the utf-8 line decoder: byte streams checked result by result against a predictor
module tb_top;

  localparam int MaxExtra      = 5;
  localparam int CycleLimit    = 200000;
  localparam int HoldOffCycles = 300;
  localparam int SettleCycles  = 4;

  typedef struct {
    logic [7:0] data;
    logic       eos;
  } stream_byte_t;

  typedef struct {
    udec_pkg::kind_e kind;
    logic [30:0]     cp;
    udec_pkg::nl_e   nl;
    udec_pkg::err_e  ec;
    logic [3:0]      cnt;
    logic            last;
  } decode_result_t;

  // opening stream: ascii extremes, the largest 31-bit codepoint, a too-long sequence cut
  // after all decodable bytes, crlf, a stray continuation, a truncated sequence ending on cr,
  // nel, and a character at stream end
  localparam logic [7:0] OpeningBytes [24] = '{
    8'h00, 8'h7F,
    8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
    8'hFE, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h41,
    8'h0D, 8'h0A,
    8'h80,
    8'hE2, 8'h80, 8'h0D,
    8'hC2, 8'h85,
    8'h7A
  };

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i     = '0;
  logic        end_of_stream_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic [1:0]  result_kind_o;
  logic [30:0] codepoint_o;
  logic [3:0]  newline_kind_o;
  logic [1:0]  error_code_o;
  logic [3:0]  error_byte_count_o;
  logic        last_of_run_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i      = '0;

  // predictor state
  logic [30:0] acc_cp       = '0;
  logic [2:0]  cont_left    = '0;
  logic [3:0]  seq_bytes    = '0;
  logic        seq_too_long = 1'b0;
  logic        cr_held      = 1'b0;
  logic [15:0] line_count   = '0;
  logic [15:0] line_limit   = udec_pkg::MAX_LEN_RESET;

  decode_result_t byte_results[$];
  decode_result_t expected_results[$];
  stream_byte_t   pending_bytes[$];

  logic in_took        = 1'b0;
  int   bytes_queued   = 0;
  int   bytes_accepted = 0;
  int   fail_count     = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_off_asked = 0;
  int   hold_off_seen  = 0;
  int   hold_left      = 0;
  int   cycle_count    = 0;

  utf8_line_decoder #(
    .MAX_EXTRA_BYTES(MaxExtra)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .end_of_stream_i   (end_of_stream_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .result_kind_o     (result_kind_o),
    .codepoint_o       (codepoint_o),
    .newline_kind_o    (newline_kind_o),
    .error_code_o      (error_code_o),
    .error_byte_count_o(error_byte_count_o),
    .last_of_run_o     (last_of_run_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void push_result(udec_pkg::kind_e kind, logic [30:0] cp,
                                      udec_pkg::nl_e nl, udec_pkg::err_e ec,
                                      logic [3:0] cnt);
    decode_result_t r;
    if (byte_results.size() >= 3) return;
    r.kind = kind;
    r.cp   = cp;
    r.nl   = nl;
    r.ec   = ec;
    r.cnt  = cnt;
    r.last = 1'b0;
    byte_results.insert(byte_results.size(), r);
  endfunction

  function automatic void end_line(udec_pkg::nl_e nl);
    push_result(udec_pkg::KIND_LINE_END, '0, nl, udec_pkg::ERR_STRAY, '0);
    line_count = '0;
  endfunction

  // an error closes the open sequence and drops the line count
  function automatic void raise_error(udec_pkg::err_e ec, logic [3:0] cnt);
    push_result(udec_pkg::KIND_ERROR, '0, udec_pkg::NL_CR, ec, cnt);
    line_count   = '0;
    acc_cp       = '0;
    cont_left    = '0;
    seq_bytes    = '0;
    seq_too_long = 1'b0;
  endfunction

  function automatic udec_pkg::err_e cut_short_code();
    return (seq_too_long && int'(seq_bytes) - 1 >= MaxExtra) ? udec_pkg::ERR_TOO_LONG
                                                              : udec_pkg::ERR_TRUNCATED;
  endfunction

  // classify a finished codepoint
  function automatic void close_char(logic [30:0] cp, logic eos);
    case (cp)
      udec_pkg::CP_CR: begin
        if (eos) end_line(udec_pkg::NL_CR);
        else cr_held = 1'b1;
      end
      udec_pkg::CP_LF:  end_line(udec_pkg::NL_LF);
      udec_pkg::CP_VT:  end_line(udec_pkg::NL_VT);
      udec_pkg::CP_FF:  end_line(udec_pkg::NL_FF);
      udec_pkg::CP_NEL: end_line(udec_pkg::NL_NEL);
      udec_pkg::CP_LS:  end_line(udec_pkg::NL_LS);
      udec_pkg::CP_PS:  end_line(udec_pkg::NL_PS);
      default: begin
        push_result(udec_pkg::KIND_CHAR, cp, udec_pkg::NL_CR, udec_pkg::ERR_STRAY, '0);
        line_count = line_count + 16'd1;
        if (line_count >= line_limit) end_line(udec_pkg::NL_LENGTH);
        else if (eos) end_line(udec_pkg::NL_EOS);
      end
    endcase
  endfunction

  // byte outside any sequence
  function automatic void open_item(logic [7:0] b, logic eos);
    int ones;
    int extra;
    ones = 0;
    while (ones < 8 && b[7-ones]) ones++;
    if (ones == 0) begin
      close_char({23'd0, b}, eos);
      return;
    end
    if (ones == 1) begin
      raise_error(udec_pkg::ERR_STRAY, 4'd1);
      return;
    end
    extra = ones - 1;
    if (eos) begin
      raise_error(udec_pkg::ERR_TRUNCATED, 4'd1);
      return;
    end
    acc_cp       = {23'd0, b & (8'hFF >> ones)};
    cont_left    = 3'(extra);
    seq_bytes    = 4'd1;
    seq_too_long = (extra > MaxExtra);
  endfunction

  // byte inside an open sequence
  function automatic void continue_item(logic [7:0] b, logic eos);
    logic [30:0] cp;
    if (b[7:6] != udec_pkg::CONT_TAG) begin
      raise_error(cut_short_code(), seq_bytes);
      open_item(b, eos);
      return;
    end
    if (int'(seq_bytes) - 1 < MaxExtra) acc_cp = {acc_cp[24:0], b[5:0]};
    seq_bytes = seq_bytes + 4'd1;
    cont_left = cont_left - 3'd1;
    if (cont_left == 3'd0) begin
      if (seq_too_long) begin
        raise_error(udec_pkg::ERR_TOO_LONG, seq_bytes);
      end else begin
        cp        = acc_cp;
        acc_cp    = '0;
        seq_bytes = '0;
        close_char(cp, eos);
      end
      return;
    end
    if (eos) raise_error(cut_short_code(), seq_bytes);
  endfunction

  // all results of one accepted byte, appended to the expected results
  function automatic void decode_byte(logic [7:0] b, logic eos);
    logic           crlf;
    decode_result_t r;
    crlf = 1'b0;
    byte_results.delete();
    // a held cr is settled by the next byte
    if (cr_held) begin
      cr_held = 1'b0;
      crlf    = (b == udec_pkg::BYTE_LF) && (seq_bytes == 4'd0);
      end_line(crlf ? udec_pkg::NL_CRLF : udec_pkg::NL_CR);
    end
    if (!crlf) begin
      if (seq_bytes == 4'd0) open_item(b, eos);
      else continue_item(b, eos);
    end
    foreach (byte_results[i]) begin
      r      = byte_results[i];
      r.last = (i == byte_results.size() - 1);
      expected_results.insert(expected_results.size(), r);
    end
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void push_byte(logic [7:0] data, logic eos);
    stream_byte_t sb;
    sb.data = data;
    sb.eos  = eos;
    pending_bytes.insert(pending_bytes.size(), sb);
    bytes_queued++;
  endfunction

  // lead byte with the given count of leading ones and random payload bits
  function automatic logic [7:0] lead_with_ones(int ones);
    logic [7:0] tag;
    logic [7:0] free;
    tag  = ~(8'hFF >> ones);
    free = 8'hFF >> (ones + 1);
    return tag | (8'($urandom) & free);
  endfunction

  // one random token: text, line breaks, whole sequences, cut sequences, strays, noise
  function automatic void queue_random_token();
    logic [7:0] token[$];
    int         pick;
    int         ones;
    int         conts;
    logic       eos_here;
    pick = $urandom_range(99);
    if (pick < 30) begin
      token.insert(token.size(), 8'($urandom_range(8'h7E, 8'h20)));
    end else if (pick < 45) begin
      case ($urandom_range(6))
        0: token.insert(token.size(), 8'h0D);
        1: token.insert(token.size(), udec_pkg::BYTE_LF);
        2: begin
          token.insert(token.size(), 8'h0D);
          token.insert(token.size(), udec_pkg::BYTE_LF);
        end
        3: token.insert(token.size(), 8'h0B);
        4: token.insert(token.size(), 8'h0C);
        5: begin
          token.insert(token.size(), 8'hC2);
          token.insert(token.size(), 8'h85);
        end
        default: begin
          token.insert(token.size(), 8'hE2);
          token.insert(token.size(), 8'h80);
          token.insert(token.size(), 8'hA8 | 8'($urandom_range(1)));
        end
      endcase
    end else if (pick < 75) begin
      // complete sequence, a few of them longer than decodable
      ones = (pick < 70) ? $urandom_range(6, 2) : $urandom_range(8, 7);
      token.insert(token.size(), lead_with_ones(ones));
      repeat (ones - 1) token.insert(token.size(), 8'h80 | 8'($urandom_range(63)));
    end else if (pick < 85) begin
      // sequence cut before its last continuation
      ones  = $urandom_range(8, 2);
      conts = $urandom_range(ones - 2);
      token.insert(token.size(), lead_with_ones(ones));
      repeat (conts) token.insert(token.size(), 8'h80 | 8'($urandom_range(63)));
    end else if (pick < 92) begin
      token.insert(token.size(), 8'h80 | 8'($urandom_range(63)));
    end else begin
      token.insert(token.size(), 8'($urandom));
    end
    eos_here = ($urandom_range(99) < 7);
    foreach (token[i]) push_byte(token[i], eos_here && (i == token.size() - 1));
  endfunction

  // wait until every byte is taken and every expected result has come
  task automatic settle();
    do @(negedge clk_i);
    while (bytes_accepted != bytes_queued || expected_results.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_line_limit(input logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] limit, input int idle_pct, input int stall_pct,
                           input int n_bytes, input bit hold_off);
    int start;
    settle();
    write_line_limit(limit);
    @(posedge clk_i);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (hold_off) hold_off_asked++;
    start = bytes_queued;
    while (bytes_queued - start < n_bytes) queue_random_token();
  endtask

  // test sequence
  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (OpeningBytes[i]) push_byte(OpeningBytes[i], i == 23);
    run_phase(16'd1, 0, 0, 28, 1'b0);
    run_phase(16'hFFFF, 73, 0, 30, 1'b0);
    run_phase(16'd5, 0, 73, 30, 1'b1);
    run_phase(16'd0, 21, 21, 18, 1'b0);
    run_phase(16'($urandom_range(12, 2)), 0, 0, 30, 1'b0);
    settle();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_top failed");
    $finish;
  end

  // byte driver, fed from the pending queue
  always @(negedge clk_i) begin : driver
    stream_byte_t offer;
    if (!in_valid_i || in_took) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offer = pending_bytes.pop_front();
        in_valid_i      <= 1'b1;
        data_byte_i     <= offer.data;
        end_of_stream_i <= offer.eos;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and a long hold-off on request
  always @(negedge clk_i) begin : receiver
    if (hold_off_seen != hold_off_asked) begin
      hold_off_seen = hold_off_asked;
      hold_left     = HoldOffCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on each accepted byte, then check each accepted result
  always @(posedge clk_i) begin : monitor
    decode_result_t want;
    if (!rst_ni) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid_i && in_ready_o;
      if (cfg_valid_i && cfg_ready_o) line_limit = cfg_data_i;
      if (in_valid_i && in_ready_o) begin
        decode_byte(data_byte_i, end_of_stream_i);
        bytes_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result of kind %0d", result_kind_o);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", want.kind, result_kind_o);
          check_field("codepoint", want.cp, codepoint_o);
          check_field("newline_kind", want.nl, newline_kind_o);
          check_field("error_code", want.ec, error_code_o);
          check_field("error_byte_count", want.cnt, error_byte_count_o);
          check_field("last_of_run", want.last, last_of_run_o);
        end
      end
    end
  end

endmodule
